@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the buffer recycle pool RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define BRP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check on every clock edge, reset included
`define BRP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hw/rtl/brp_pkg.sv @@
// Types and codes shared by the buffer recycle pool modules
`timescale 1ns / 1ps
package brp_pkg;

   localparam int HANDLE_W  = 20;
   localparam int CAP_W     = 11;
   localparam int CSR_W     = 11;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [2:0] {
      OUT_FROM_CACHE = 3'd0,
      OUT_FROM_RING  = 3'd1,
      OUT_NONE       = 3'd2,
      OUT_INTO_CACHE = 3'd3,
      OUT_INTO_RING  = 3'd4,
      OUT_FULL_FREED = 3'd5,
      OUT_SHARED     = 3'd6
   } outcome_type;

   typedef enum logic [0:0] {
      CSR_DMA_MAP  = 1'b0,
      CSR_RING_CAP = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      SRC_CACHE,
      SRC_RING,
      SRC_REQ,
      SRC_ZERO
   } src_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REFILL_RD,
      ST_REFILL_WR,
      ST_RD_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        idle;
      logic        req_take;
      logic        cache_push;
      logic        cache_pop;
      logic        ring_push;
      logic        ring_pop;
      logic        refill_load;
      logic        refill_wr;
      logic        out_load;
      src_type     out_src;
      outcome_type outcome;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic release_req;
      logic sole;
      logic direct;
      logic fast;
      logic cache_empty;
      logic cache_full;
      logic ring_empty;
      logic ring_room;
      logic refill_done;
      logic rsp_free;
   } status_type;

endpackage

@@ hw/rtl/brp_ctrl.sv @@
// Controller state machine of the buffer recycle pool
`timescale 1ns / 1ps
module brp_ctrl
   import brp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output cmd_type    cmd
);

   state_type   state_ff, state_in;
   src_type     src_ff, src_in;
   outcome_type outcome_ff, outcome_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      src_ff     <= src_in;
      outcome_ff <= outcome_in;
   end

   // next state and result selection
   always_comb begin
      state_in   = state_ff;
      src_in     = src_ff;
      outcome_in = outcome_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.release_req) begin
               src_in   = SRC_REQ;
               state_in = ST_OUT;
               if (!status.sole) outcome_in = OUT_SHARED;
               else if (status.direct && status.fast && !status.cache_full)
                  outcome_in = OUT_INTO_CACHE;
               else if (status.ring_room) outcome_in = OUT_INTO_RING;
               else outcome_in = OUT_FULL_FREED;
            end else if (status.fast) begin
               if (!status.cache_empty) begin
                  src_in = SRC_CACHE; outcome_in = OUT_FROM_CACHE; state_in = ST_RD_WAIT;
               end else if (!status.ring_empty) begin
                  state_in = ST_REFILL_RD;
               end else begin
                  src_in = SRC_ZERO; outcome_in = OUT_NONE; state_in = ST_OUT;
               end
            end else if (!status.ring_empty) begin
               src_in = SRC_RING; outcome_in = OUT_FROM_RING; state_in = ST_RD_WAIT;
            end else begin
               src_in = SRC_ZERO; outcome_in = OUT_NONE; state_in = ST_OUT;
            end
         end
         ST_REFILL_RD: state_in = ST_REFILL_WR;
         ST_REFILL_WR: state_in = status.refill_done ? ST_EXEC : ST_REFILL_RD;
         ST_RD_WAIT:   state_in = ST_OUT;
         ST_OUT: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd         = '0;
      cmd.out_src = src_ff;
      cmd.outcome = outcome_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.idle     = 1'b1;
            cmd.req_take = status.req_valid;
         end
         ST_EXEC: begin
            if (status.release_req) begin
               if (status.sole) begin
                  if (status.direct && status.fast && !status.cache_full)
                     cmd.cache_push = 1'b1;
                  else if (status.ring_room) cmd.ring_push = 1'b1;
               end
            end else if (status.fast) begin
               if (!status.cache_empty) cmd.cache_pop = 1'b1;
               else if (!status.ring_empty) cmd.refill_load = 1'b1;
            end else if (!status.ring_empty) begin
               cmd.ring_pop = 1'b1;
            end
         end
         ST_REFILL_RD: cmd.ring_pop  = 1'b1;
         ST_REFILL_WR: cmd.refill_wr = 1'b1;
         ST_OUT:       cmd.out_load  = status.rsp_free;
         default: ;
      endcase
   end

endmodule

@@ hw/rtl/brp_dpath.sv @@
// Datapath of the buffer recycle pool: stores, counters, settings, result register
`timescale 1ns / 1ps
module brp_dpath
   import brp_pkg::*;
#(
   parameter int CACHE_DEPTH  = 128,
   parameter int REFILL_COUNT = 64,
   parameter int RING_DEPTH   = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  req_tvalid,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]            rsp_tuser,
   input  logic                  csr_we,
   input  logic [0:0]            csr_addr,
   input  logic [CSR_W-1:0]      csr_wdata
);
   `include "assert_macros.svh"

   localparam int CAW = $clog2(CACHE_DEPTH);
   localparam int CW  = $clog2(CACHE_DEPTH + 1);
   localparam int RAW = $clog2(RING_DEPTH);
   localparam int FW  = $clog2(RING_DEPTH + 1);
   localparam int REFILL_MAX = (REFILL_COUNT < CACHE_DEPTH) ? REFILL_COUNT : CACHE_DEPTH;

   logic [HANDLE_W-1:0] cache_mem [CACHE_DEPTH];
   logic [HANDLE_W-1:0] ring_mem [RING_DEPTH];
   logic [HANDLE_W-1:0] cache_rdata_ff, ring_rdata_ff;

   logic                dma_en_ff;
   logic [CAP_W-1:0]    cap_ff;
   logic [CW-1:0]       cache_fill_ff, cache_fill_in;
   logic [FW-1:0]       ring_fill_ff, ring_fill_in;
   logic [RAW-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]       refill_cnt_ff, refill_cnt_in;

   logic                action_ff, sole_ff, direct_ff, fast_ff;
   logic [HANDLE_W-1:0] handle_ff;

   logic                rsp_valid_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic [2:0]          rsp_outcome_ff;
   logic                rsp_unmap_ff;

   logic [31:0]         ring_limit;
   logic                cache_wr;
   logic [CAW-1:0]      cache_waddr, cache_raddr;
   logic [HANDLE_W-1:0] cache_wdata, res_handle;

   assign ring_limit = (cap_ff == '0 || 32'(cap_ff) > RING_DEPTH) ? RING_DEPTH : 32'(cap_ff);

   assign status.req_valid   = req_tvalid;
   assign status.release_req = action_ff;
   assign status.sole        = sole_ff;
   assign status.direct      = direct_ff;
   assign status.fast        = fast_ff;
   assign status.cache_empty = (cache_fill_ff == '0);
   assign status.cache_full  = (32'(cache_fill_ff) >= CACHE_DEPTH);
   assign status.ring_empty  = (ring_fill_ff == '0);
   assign status.ring_room   = (32'(ring_fill_ff) < ring_limit);
   assign status.refill_done = (refill_cnt_ff == '0);
   assign status.rsp_free    = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dma_en_ff <= 1'b0;
         cap_ff    <= CAP_W'(1024);
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_DMA_MAP:  dma_en_ff <= csr_wdata[0];
            CSR_RING_CAP: cap_ff    <= csr_wdata[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_take) begin
         handle_ff <= req_tdata[HANDLE_W-1:0];
         sole_ff   <= req_tdata[HANDLE_W];
         direct_ff <= req_tdata[HANDLE_W+1];
         fast_ff   <= req_tdata[HANDLE_W+2];
         action_ff <= req_tuser;
      end
   end

   // cache write/read addresses
   assign cache_wr    = cmd.cache_push || cmd.refill_wr;
   assign cache_waddr = cache_fill_ff[CAW-1:0];
   assign cache_raddr = CAW'(cache_fill_ff - CW'(1));
   assign cache_wdata = cmd.refill_wr ? ring_rdata_ff : handle_ff;

   always_ff @(posedge clock) begin
      if (cache_wr) cache_mem[cache_waddr] <= cache_wdata;
      if (cmd.cache_pop) cache_rdata_ff <= cache_mem[cache_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.ring_push) ring_mem[tail_ff] <= handle_ff;
      if (cmd.ring_pop) ring_rdata_ff <= ring_mem[head_ff];
   end

   always_comb begin
      cache_fill_in = cache_fill_ff;
      if (cache_wr) cache_fill_in = cache_fill_ff + CW'(1);
      else if (cmd.cache_pop) cache_fill_in = cache_fill_ff - CW'(1);

      ring_fill_in = ring_fill_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      if (cmd.ring_push) begin
         ring_fill_in = ring_fill_ff + FW'(1);
         tail_in = (32'(tail_ff) == RING_DEPTH - 1) ? '0 : tail_ff + RAW'(1);
      end else if (cmd.ring_pop) begin
         ring_fill_in = ring_fill_ff - FW'(1);
         head_in = (32'(head_ff) == RING_DEPTH - 1) ? '0 : head_ff + RAW'(1);
      end

      refill_cnt_in = refill_cnt_ff;
      if (cmd.refill_load)
         refill_cnt_in = (32'(ring_fill_ff) < REFILL_MAX) ? CW'(ring_fill_ff) : CW'(REFILL_MAX);
      else if (cmd.ring_pop && refill_cnt_ff != '0)
         refill_cnt_in = refill_cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cache_fill_ff <= '0;
         ring_fill_ff  <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         refill_cnt_ff <= '0;
      end else begin
         cache_fill_ff <= cache_fill_in;
         ring_fill_ff  <= ring_fill_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         refill_cnt_ff <= refill_cnt_in;
      end
   end

   always_comb begin
      case (cmd.out_src)
         SRC_CACHE: res_handle = cache_rdata_ff;
         SRC_RING:  res_handle = ring_rdata_ff;
         SRC_REQ:   res_handle = handle_ff;
         default:   res_handle = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_handle_ff  <= res_handle;
         rsp_outcome_ff <= cmd.outcome;
         rsp_unmap_ff   <= dma_en_ff &&
            (cmd.outcome == OUT_FULL_FREED || cmd.outcome == OUT_SHARED);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - HANDLE_W - 1){1'b0}}, rsp_unmap_ff, rsp_handle_ff};
   assign rsp_tuser  = rsp_outcome_ff;

   `BRP_ASSERT(a_cache_fill_bound, (32'(cache_fill_ff) <= CACHE_DEPTH), "cache fill overflow")
   `BRP_ASSERT(a_ring_fill_bound, (32'(ring_fill_ff) <= RING_DEPTH), "ring fill overflow")
   `BRP_ASSERT(a_refill_room, (cmd.refill_wr |-> !status.cache_full), "refill into full cache")
   `BRP_ASSERT(a_load_free, (cmd.out_load |-> status.rsp_free), "result overwritten")

endmodule

@@ hw/rtl/buffer_recycle_pool.sv @@
// Top level of the buffer recycle pool: two-level free handle cache and ring
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata: handle, sole, direct, fast; tuser: action
//  rsp     | out | rsp_tvalid/tready    | tdata: handle, unmap; tuser: outcome
//  csr     | in  | csr_we               | csr_addr, csr_wdata
//
// A release, or an allocate that finds nothing, passes execute and output states; one
// served from cache or ring adds a read-wait state. An empty-cache refill moves each
// handle by a ring read then a cache write state, as one ring read port feeds the
// cache write port. Requests are taken one at a time; the next is accepted while a result
// waits. A stalled result holds the block in its output state. Reset is synchronous.
`timescale 1ns / 1ps
module buffer_recycle_pool
   import brp_pkg::*;
#(
   parameter int CACHE_DEPTH  = 128,
   parameter int REFILL_COUNT = 64,
   parameter int RING_DEPTH   = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // handle[19:0], sole_owner, direct_ok, fast_context
   input  logic                  req_tuser,  // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_handle[19:0], unmap_needed
   output logic [2:0]            rsp_tuser,  // outcome
   input  logic                  csr_we,
   input  logic [0:0]            csr_addr,
   input  logic [CSR_W-1:0]      csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign req_tready = cmd.idle;

   brp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   brp_dpath #(
      .CACHE_DEPTH  (CACHE_DEPTH),
      .REFILL_COUNT (REFILL_COUNT),
      .RING_DEPTH   (RING_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

endmodule

@@ tb/tb_buffer_recycle_pool.sv @@
// Self-checking testbench for the buffer recycle pool: streams allocate and release requests
`timescale 1ns / 1ps
module tb_buffer_recycle_pool;
   import brp_pkg::*;

   localparam int CACHE_DEPTH  = 128;
   localparam int REFILL_COUNT = 64;
   localparam int RING_DEPTH   = 1024;
   localparam int WATCHDOG     = 20000;

   typedef struct packed {
      logic        action;
      logic [19:0] handle;
      logic        sole;
      logic        direct;
      logic        fast;
   } pool_req_type;

   typedef struct packed {
      logic [19:0] handle;
      outcome_type outcome;
      logic        unmap;
   } pool_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // handle[19:0], sole_owner, direct_ok, fast_context
   logic req_tuser = 1'b0;                 // action
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // out_handle[19:0], unmap_needed
   logic [2:0] rsp_tuser;                  // outcome
   logic csr_we = 1'b0;
   logic [0:0] csr_addr = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   always #2 clock = ~clock;

   buffer_recycle_pool i_dut (.*);

   // predictor state
   logic [19:0] cache_mem [CACHE_DEPTH];
   int          cache_cnt;
   logic [19:0] ring_mem [RING_DEPTH];
   int          ring_rd, ring_wr, ring_cnt;
   logic        map_en;
   int          ring_cap;

   pool_req_type pending_reqs[$];
   pool_rsp_type expected_rsps[$];
   int          send_idle_pct, recv_idle_pct;
   int          errors = 0;
   int          idle_cycles = 0;
   logic        req_fire = 1'b0;

   function automatic logic [19:0] ring_take();
      logic [19:0] h;
      h = ring_mem[ring_rd];
      ring_rd = (ring_rd + 1) % RING_DEPTH;
      ring_cnt--;
      return h;
   endfunction

   function automatic pool_rsp_type predict_pool(pool_req_type r);
      pool_rsp_type p;
      int n, lim;
      p.handle = '0;
      p.outcome = OUT_NONE;
      p.unmap = 1'b0;
      lim = (ring_cap == 0 || ring_cap > RING_DEPTH) ? RING_DEPTH : ring_cap;
      if (!r.action) begin
         if (r.fast) begin
            if (cache_cnt == 0) begin
               n = REFILL_COUNT < CACHE_DEPTH ? REFILL_COUNT : CACHE_DEPTH;
               if (n > ring_cnt) n = ring_cnt;
               repeat (n) begin
                  cache_mem[cache_cnt] = ring_take();
                  cache_cnt++;
               end
            end
            if (cache_cnt > 0) begin
               cache_cnt--;
               p.handle = cache_mem[cache_cnt];
               p.outcome = OUT_FROM_CACHE;
            end
         end else if (ring_cnt > 0) begin
            p.handle = ring_take();
            p.outcome = OUT_FROM_RING;
         end
      end else begin
         p.handle = r.handle;
         if (r.sole) begin
            if (r.direct && r.fast && cache_cnt < CACHE_DEPTH) begin
               cache_mem[cache_cnt] = r.handle;
               cache_cnt++;
               p.outcome = OUT_INTO_CACHE;
            end else if (ring_cnt < lim) begin
               ring_mem[ring_wr] = r.handle;
               ring_wr = (ring_wr + 1) % RING_DEPTH;
               ring_cnt++;
               p.outcome = OUT_INTO_RING;
            end else begin
               p.outcome = OUT_FULL_FREED;
               p.unmap = map_en;
            end
         end else begin
            p.outcome = OUT_SHARED;
            p.unmap = map_en;
         end
      end
      return p;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_fire) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               pool_req_type r;
               r = pending_reqs.pop_front();
               req_tdata <= {1'b0, r.fast, r.direct, r.sole, r.handle};
               req_tuser <= r.action;
               req_tvalid <= 1'b1;
               expected_rsps.push_back(predict_pool(r));
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         req_fire <= req_tvalid && req_tready;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response %h/%0d", rsp_tdata, rsp_tuser);
            end else begin
               pool_rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_tdata[19:0] !== e.handle || rsp_tuser !== e.outcome
                   || rsp_tdata[20] !== e.unmap) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp h=%h o=%0d u=%b got h=%h o=%0d u=%b",
                              e.handle, e.outcome, e.unmap,
                              rsp_tdata[19:0], rsp_tuser, rsp_tdata[20]);
               end
            end
         end
         if (idle_cycles >= WATCHDOG) begin
            $display("[buffer_recycle_pool] ERROR");
            $finish;
         end
      end
   end

   task automatic csr_write(csr_index_type idx, int val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val[CSR_W-1:0];
      if (idx == CSR_DMA_MAP) map_en = val[0];
      else ring_cap = val & 'h7FF;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_req(bit act, logic [19:0] h, bit s, bit d, bit f);
      pool_req_type r;
      r.action = act;
      r.handle = h;
      r.sole = s;
      r.direct = d;
      r.fast = f;
      pending_reqs.push_back(r);
   endtask

   task automatic drain();
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         int k;
         k = $urandom_range(99);
         if (k < 45)
            add_req(1'b0, 20'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
         else if (k < 90)
            add_req(1'b1, 20'($urandom), 1'b1, 1'($urandom), 1'($urandom));
         else
            add_req(1'b1, 20'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      cache_cnt = 0; ring_rd = 0; ring_wr = 0; ring_cnt = 0;
      map_en = 1'b0; ring_cap = 1024;
      send_idle_pct = 8; recv_idle_pct = 51;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty pool, extremes, cache and ring paths, refill, shared
      csr_write(CSR_DMA_MAP, 1);
      csr_write(CSR_RING_CAP, 2);
      add_req(1'b0, 20'hFFFFF, 1, 1, 1);
      add_req(1'b0, 20'h00000, 0, 0, 0);
      add_req(1'b1, 20'hFFFFF, 1, 1, 1);
      add_req(1'b1, 20'h00000, 1, 0, 1);
      add_req(1'b1, 20'h12345, 1, 1, 0);
      add_req(1'b1, 20'hABCDE, 1, 0, 0);
      add_req(1'b1, 20'h55555, 0, 1, 1);
      add_req(1'b0, 20'h0, 0, 0, 0);
      add_req(1'b0, 20'h0, 0, 0, 1);
      add_req(1'b0, 20'h0, 0, 0, 1);
      add_req(1'b0, 20'h0, 0, 0, 1);
      add_req(1'b0, 20'h0, 0, 0, 1);
      drain();
      csr_write(CSR_RING_CAP, 1024);
      csr_write(CSR_DMA_MAP, 0);
      for (int i = 0; i < 70; i++) add_req(1'b1, 20'($urandom), 1, 0, 0);
      add_req(1'b1, 20'h0F0F0, 1, 1, 1);
      add_req(1'b0, 20'h0, 0, 0, 1);
      add_req(1'b0, 20'h0, 0, 0, 1);
      add_req(1'b0, 20'h0, 0, 0, 0);
      drain();

      random_phase(110);
      drain();
      csr_write(CSR_RING_CAP, 1);
      csr_write(CSR_DMA_MAP, 1);
      send_idle_pct = 51; recv_idle_pct = 8;
      random_phase(110);
      drain();
      csr_write(CSR_RING_CAP, 0);
      send_idle_pct = 0; recv_idle_pct = 0;
      random_phase(50);
      drain();
      csr_write(CSR_RING_CAP, 2047);
      random_phase(50);
      drain();

      if (errors == 0) $display("[buffer_recycle_pool] OK");
      else $display("[buffer_recycle_pool] ERROR");
      $finish;
   end

endmodule
